### rtl/core/jte_pkg.sv
// ----------------------------------------------------------------------------
// jte_pkg
// Shared types and constants for the JUMBF typed box extractor.
// ----------------------------------------------------------------------------
package jte_pkg;

  localparam int unsigned HoldDepth = 24;
  localparam int unsigned BurstLen  = 32;

  localparam logic [7:0]  MarkerLead = 8'hFF;
  localparam logic [7:0]  MkSoi      = 8'hD8;
  localparam logic [7:0]  MkEoi      = 8'hD9;
  localparam logic [7:0]  MkSos      = 8'hDA;
  localparam logic [7:0]  MkApp11    = 8'hEB;
  localparam logic [15:0] App11Hdr   = 16'd18;
  localparam logic [31:0] JumbTbox   = 32'h6a756d62;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NOT_JPEG  = 3'd2,
    ST_MARKER    = 3'd3,
    ST_SIZE      = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_BAD_LEN   = 3'd6
  } status_e;

  // one parsed file byte turns into this description of its results
  typedef struct packed {
    logic                    one_byte;
    logic                    burst;
    logic [7:0]              byte_val;
    logic [BurstLen-1:0][7:0] burst_bytes;
    logic                    fin;
    status_e                 status;
    logic [31:0]             size;
  } step_t;

  function automatic logic [127:0] type_uuid(input logic [2:0] t);
    logic [127:0] u;
    begin
      unique case (t)
        3'd0: u = 128'h6579D6FB_DBA2446B_B2AC1B82_FEEB89D1;
        3'd1: u = 128'h786D6C20_00110010_800000AA_00389B71;
        3'd2: u = 128'h6A736F6E_00110010_800000AA_00389B71;
        3'd3: u = 128'h75756964_00110010_800000AA_00389B71;
        3'd4: u = 128'h40CB0C32_BB8A489D_A70B2AD6_F47F4369;
        3'd5: u = 128'h63626F72_00110010_800000AA_00389B71;
        default: u = '0;
      endcase
      return u;
    end
  endfunction

endpackage

### rtl/core/jte_parser.sv
// ----------------------------------------------------------------------------
// jte_parser
// Marker segment walker: one file byte per accepted word, state update and
// result description in a single pass.
// ----------------------------------------------------------------------------
module jte_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_wdata_i,
  input  logic          take_i,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_stream_i,
  output jte_pkg::step_t step_o
);
  import jte_pkg::*;

  localparam logic [3:0] PH_SOI0 = 4'd0;
  localparam logic [3:0] PH_SOI1 = 4'd1;
  localparam logic [3:0] PH_MK0  = 4'd2;
  localparam logic [3:0] PH_MK1  = 4'd3;
  localparam logic [3:0] PH_LEN  = 4'd4;
  localparam logic [3:0] PH_SKIP = 4'd5;
  localparam logic [3:0] PH_AHDR = 4'd6;
  localparam logic [3:0] PH_HOLD = 4'd7;
  localparam logic [3:0] PH_EMIT = 4'd8;
  localparam logic [3:0] PH_DONE = 4'd9;

  logic [2:0]  wtype_q;
  logic [3:0]  phase_q, phase_d;
  logic [4:0]  fc_q, fc_d;
  logic [15:0] seglen_q, seglen_d, skip_q, skip_d, inst_q, inst_d, linst_q, linst_d;
  logic [31:0] seq_q, seq_d, blen_q, blen_d, btype_q, btype_d;
  logic [31:0] expseq_q, expseq_d, llen_q, llen_d, cnt_q, cnt_d;
  logic        found_q, found_d;
  logic [7:0]  hold_q [HoldDepth];
  logic        hold_we;

  logic        push1, burst, fin;
  status_e     fst;
  logic [5:0]  inc;
  logic [32:0] sum;
  logic [127:0] cand;
  logic        match;
  logic [BurstLen-1:0][7:0] bb;
  logic [15:0] nl;
  logic [15:0] sk;

  always_comb begin
    for (int i = 0; i < 15; i++) begin
      cand[127-8*i -: 8] = hold_q[8+i];
    end
    cand[7:0] = in_byte_i;
    match = (wtype_q < 3'd6) && (cand == type_uuid(wtype_q));
    bb[0] = blen_q[31:24];
    bb[1] = blen_q[23:16];
    bb[2] = blen_q[15:8];
    bb[3] = blen_q[7:0];
    bb[4] = btype_q[31:24];
    bb[5] = btype_q[23:16];
    bb[6] = btype_q[15:8];
    bb[7] = btype_q[7:0];
    for (int i = 0; i < HoldDepth - 1; i++) begin
      bb[8+i] = hold_q[i];
    end
    bb[BurstLen-1] = in_byte_i;
  end

  always_comb begin
    phase_d = phase_q; fc_d = fc_q; seglen_d = seglen_q; skip_d = skip_q;
    inst_d = inst_q; seq_d = seq_q; blen_d = blen_q; btype_d = btype_q;
    linst_d = linst_q; expseq_d = expseq_q; llen_d = llen_q; found_d = found_q;
    hold_we = 1'b0; push1 = 1'b0; burst = 1'b0; fin = 1'b0; fst = ST_OK;
    nl = {seglen_q[7:0], in_byte_i};
    sk = skip_q - 16'd1;
    if (phase_q != PH_DONE) begin
      unique case (phase_q)
        PH_SOI0: begin
          if (in_byte_i == MarkerLead) phase_d = PH_SOI1;
          else begin fin = 1'b1; fst = ST_NOT_JPEG; end
        end
        PH_SOI1: begin
          if (in_byte_i == MkSoi) phase_d = PH_MK0;
          else begin fin = 1'b1; fst = ST_NOT_JPEG; end
        end
        PH_MK0: begin
          if (in_byte_i == MarkerLead) phase_d = PH_MK1;
          else begin fin = 1'b1; fst = ST_MARKER; end
        end
        PH_MK1: begin
          fc_d = '0;
          seglen_d = '0;
          if (in_byte_i == MkSos || in_byte_i == MkSoi || in_byte_i == MkEoi) begin
            fin = 1'b1;
            if (!found_q) fst = ST_NOT_FOUND;
            else if (llen_q == cnt_q) fst = ST_OK;
            else fst = ST_SIZE;
          end else if (in_byte_i == MkApp11) phase_d = PH_AHDR;
          else phase_d = PH_LEN;
        end
        PH_LEN: begin
          seglen_d = nl;
          fc_d = fc_q + 5'd1;
          if (fc_q != 5'd0) begin
            if (nl < 16'd2) begin
              fin = 1'b1; fst = ST_BAD_LEN;
            end else begin
              skip_d = nl - 16'd2;
              phase_d = (skip_d != '0) ? PH_SKIP : PH_MK0;
            end
          end
        end
        PH_SKIP: begin
          skip_d = sk;
          if (sk == '0) phase_d = PH_MK0;
        end
        PH_AHDR: begin
          if (fc_q < 5'd2) seglen_d = nl;
          else if (fc_q < 5'd4) seglen_d = seglen_q;
          else if (fc_q < 5'd6) inst_d = {inst_q[7:0], in_byte_i};
          else if (fc_q < 5'd10) seq_d = {seq_q[23:0], in_byte_i};
          else if (fc_q < 5'd14) blen_d = {blen_q[23:0], in_byte_i};
          else btype_d = {btype_q[23:0], in_byte_i};
          fc_d = fc_q + 5'd1;
          if (fc_q == 5'd1 && nl < App11Hdr) begin
            fin = 1'b1; fst = ST_BAD_LEN;
          end else if (fc_q >= 5'd17) begin
            skip_d = seglen_q - App11Hdr;
            fc_d = '0;
            if (found_q && inst_q == linst_q && seq_q == expseq_q) begin
              expseq_d = expseq_q + 32'd1;
              phase_d = PH_EMIT;
            end else if (!found_q && btype_d == JumbTbox && seq_q == 32'd1) begin
              phase_d = PH_HOLD;
            end else begin
              phase_d = PH_SKIP;
            end
            if (skip_d == '0) phase_d = PH_MK0;
          end
        end
        PH_HOLD: begin
          hold_we = 1'b1;
          fc_d = fc_q + 5'd1;
          skip_d = sk;
          if (fc_q >= 5'(HoldDepth - 1)) begin
            if (match) begin
              found_d = 1'b1;
              linst_d = inst_q;
              expseq_d = 32'd2;
              llen_d = blen_q;
              burst = 1'b1;
              phase_d = PH_EMIT;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          if (sk == '0) phase_d = PH_MK0;
        end
        PH_EMIT: begin
          push1 = 1'b1;
          skip_d = sk;
          if (sk == '0) phase_d = PH_MK0;
        end
        default: ;
      endcase
      if (end_of_stream_i && !fin) begin
        fin = 1'b1; fst = ST_TRUNC;
      end
      if (fin) phase_d = PH_DONE;
    end
    inc = burst ? 6'(BurstLen) : {5'd0, push1};
    sum = {1'b0, cnt_q} + {27'd0, inc};
    cnt_d = sum[32] ? '1 : sum[31:0];
  end

  always_comb begin
    step_o.one_byte    = take_i & push1;
    step_o.burst       = take_i & burst;
    step_o.byte_val    = in_byte_i;
    step_o.burst_bytes = bb;
    step_o.fin         = take_i & fin;
    step_o.status      = fst;
    step_o.size        = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wtype_q <= '0;
      phase_q <= PH_SOI0; fc_q <= '0; seglen_q <= '0; skip_q <= '0;
      inst_q <= '0; seq_q <= '0; blen_q <= '0; btype_q <= '0;
      linst_q <= '0; expseq_q <= '0; llen_q <= '0; cnt_q <= '0; found_q <= 1'b0;
    end else begin
      if (cfg_we_i) wtype_q <= cfg_wdata_i;
      if (take_i) begin
        if (end_of_stream_i) begin
          phase_q <= PH_SOI0; fc_q <= '0; seglen_q <= '0; skip_q <= '0;
          inst_q <= '0; seq_q <= '0; blen_q <= '0; btype_q <= '0;
          linst_q <= '0; expseq_q <= '0; llen_q <= '0; cnt_q <= '0; found_q <= 1'b0;
        end else begin
          phase_q <= phase_d; fc_q <= fc_d; seglen_q <= seglen_d; skip_q <= skip_d;
          inst_q <= inst_d; seq_q <= seq_d; blen_q <= blen_d; btype_q <= btype_d;
          linst_q <= linst_d; expseq_q <= expseq_d; llen_q <= llen_d;
          cnt_q <= cnt_d; found_q <= found_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && hold_we && fc_q < 5'(HoldDepth)) begin
      hold_q[fc_q] <= in_byte_i;
    end
  end

endmodule

### rtl/core/jte_emitter.sv
// ----------------------------------------------------------------------------
// jte_emitter
// Result register: holds the words of one step and hands them out one per
// cycle while out_ready_i is high, the done report on the last one.
// ----------------------------------------------------------------------------
module jte_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jte_pkg::step_t step_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           byte_valid_o,
  output logic           box_start_o,
  output logic           run_last_o,
  output logic           done_res_o,
  output logic [2:0]     status_o,
  output logic [31:0]    collected_size_o
);
  import jte_pkg::*;

  logic [BurstLen-1:0][7:0] sh_q;
  logic [5:0]  rem_q;
  logic        bv_q, first_q, fin_q;
  status_e     st_q;
  logic [31:0] size_q;
  logic        pop, last;

  assign out_valid_o = rem_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign last        = rem_q == 6'd1;
  assign free_o      = (rem_q == '0) || (last && out_ready_i);

  assign out_byte_o       = bv_q ? sh_q[0] : 8'd0;
  assign byte_valid_o     = bv_q;
  assign box_start_o      = bv_q & first_q;
  assign run_last_o       = last;
  assign done_res_o       = last & fin_q;
  assign status_o         = (last & fin_q) ? st_q : ST_OK;
  assign collected_size_o = (last & fin_q) ? size_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      bv_q    <= 1'b0;
      first_q <= 1'b0;
      fin_q   <= 1'b0;
    end else if (step_i.burst) begin
      rem_q <= 6'(BurstLen); bv_q <= 1'b1; first_q <= 1'b1; fin_q <= step_i.fin;
    end else if (step_i.one_byte || step_i.fin) begin
      rem_q <= 6'd1; bv_q <= step_i.one_byte; first_q <= 1'b0; fin_q <= step_i.fin;
    end else if (pop) begin
      rem_q   <= rem_q - 6'd1;
      first_q <= 1'b0;
      if (last) begin
        bv_q  <= 1'b0;
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.burst) begin
      sh_q <= step_i.burst_bytes;
    end else if (step_i.one_byte) begin
      sh_q[0] <= step_i.byte_val;
    end else if (pop) begin
      for (int i = 0; i < BurstLen - 1; i++) begin
        sh_q[i] <= sh_q[i+1];
      end
    end
    if (step_i.fin) begin
      st_q   <= step_i.status;
      size_q <= step_i.size;
    end
  end

endmodule

### rtl/core/jumbf_typed_box_extractor_unit.sv
// ----------------------------------------------------------------------------
// jumbf_typed_box_extractor_unit
// Extracts the JUMBF box of a chosen content type from a JPEG byte stream.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i/in_ready_o  | in_byte_i, end_of_stream_i
//  out     | out_valid_o/out_ready_i| out_byte_o .. collected_size_o
//  cfg     | cfg_we_i               | cfg_wdata_i (wanted type)
//
// One file byte per ready cycle. A byte that completes a type match yields 32
// output words (box header plus held payload); input waits while they drain.
// Other bytes yield zero or one word. The output register lets the next
// byte in during the cycle the last word is taken. Reset is async, active low.
module jumbf_typed_box_extractor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        box_start_o,
  output logic        run_last_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic [31:0] collected_size_o
);
  import jte_pkg::*;

  step_t step;
  logic  free;
  logic  take;

  assign in_ready_o = free;
  assign take       = in_valid_i & free;

  jte_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .take_i          (take),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .step_o          (step)
  );

  jte_emitter u_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .free_o           (free),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .box_start_o      (box_start_o),
    .run_last_o       (run_last_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .collected_size_o (collected_size_o)
  );

endmodule
